// File: rtl/srfo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the section RVA to file offset unit.
// Used by srfo_cell and section_rva_to_file_offset_unit; no dependencies.

package srfo_pkg;

    localparam int MAX_SECTIONS = 16;
    localparam int ADDR_W       = 32;
    localparam int SLOT_W       = 4;
    localparam int COUNT_W      = 5;

    typedef enum logic [0:0] {
        ACT_LOAD      = 1'b0,
        ACT_TRANSLATE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_MAPPED  = 2'd0,
        ST_HEADER  = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        CFG_SECTION_COUNT = 1'b0,
        CFG_FILE_SIZE     = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic              valid;
        logic              is_load;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] vsize;
        logic [ADDR_W-1:0] rsize;
        logic [ADDR_W-1:0] ptr;
        logic [ADDR_W-1:0] addr;
        logic              hit;
        logic [SLOT_W-1:0] hit_idx;
        logic [ADDR_W-1:0] offset;
        logic              below_first;
    } t_token;

endpackage

`default_nettype wire

// File: rtl/section_rva_to_file_offset_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the section RVA to file offset unit: a chain of srfo_cell
// instances, one per table entry, and the output register.
// Depends on srfo_pkg and srfo_cell.
//
//  channel | signals                           | direction
//  --------+-----------------------------------+----------
//  in      | i_in_valid / o_in_ready, fields   | item in
//  out     | o_out_valid / i_out_ready, fields | item out
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data | write only
//
// Items enter one per cycle and walk the chain one cell per cycle unless it
// stalls; a translate result passes each cell register, then the output one.
// Load items travel the same chain, so table updates keep item order.
// A pending, untaken result stalls the whole chain and drops o_in_ready.
// Reset empties the chain and clears section_count and file_size.

module section_rva_to_file_offset_unit #(
    parameter int MAX_SECTIONS = srfo_pkg::MAX_SECTIONS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_action,
    input  wire logic [srfo_pkg::SLOT_W-1:0]   i_entry_index,
    input  wire logic [srfo_pkg::ADDR_W-1:0]   i_entry_virt_start,
    input  wire logic [srfo_pkg::ADDR_W-1:0]   i_entry_virt_size,
    input  wire logic [srfo_pkg::ADDR_W-1:0]   i_entry_raw_size,
    input  wire logic [srfo_pkg::ADDR_W-1:0]   i_entry_raw_pointer,
    input  wire logic [srfo_pkg::ADDR_W-1:0]   i_query_address,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [srfo_pkg::ADDR_W-1:0]        o_file_offset,
    output logic [1:0]                         o_status,
    output logic [srfo_pkg::SLOT_W-1:0]        o_hit_index,
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_index,
    input  wire logic [srfo_pkg::ADDR_W-1:0]   i_cfg_data
);

    logic [srfo_pkg::COUNT_W-1:0] r_section_count;
    logic [srfo_pkg::ADDR_W-1:0]  r_file_size;
    logic                         r_out_valid;
    logic [srfo_pkg::ADDR_W-1:0]  r_file_offset;
    logic [1:0]                   r_status;
    logic [srfo_pkg::SLOT_W-1:0]  r_hit_index;

    logic                         w_advance;
    srfo_pkg::t_token             w_head;
    srfo_pkg::t_token             w_chain [MAX_SECTIONS+1];
    srfo_pkg::t_token             w_last;

    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready = w_advance;

    always_comb begin
        w_head             = '0;
        w_head.valid       = i_in_valid;
        w_head.is_load     = (i_action == srfo_pkg::ACT_LOAD);
        w_head.slot        = i_entry_index;
        w_head.start       = i_entry_virt_start;
        w_head.vsize       = i_entry_virt_size;
        w_head.rsize       = i_entry_raw_size;
        w_head.ptr         = i_entry_raw_pointer;
        w_head.addr        = i_query_address;
    end

    assign w_chain[0] = w_head;

    for (genvar g = 0; g < MAX_SECTIONS; g++) begin : g_cell
        srfo_cell #(
            .P_INDEX (g)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_advance       (w_advance),
            .i_section_count (r_section_count),
            .i_tok           (w_chain[g]),
            .o_tok           (w_chain[g+1])
        );
    end

    assign w_last = w_chain[MAX_SECTIONS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_count <= '0;
            r_file_size     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                srfo_pkg::CFG_SECTION_COUNT: r_section_count <= i_cfg_data[srfo_pkg::COUNT_W-1:0];
                srfo_pkg::CFG_FILE_SIZE:     r_file_size     <= i_cfg_data;
                default:                     r_file_size     <= r_file_size;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_last.valid && !w_last.is_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            if (w_last.hit) begin
                r_hit_index <= w_last.hit_idx;
                if (w_last.offset > r_file_size) begin
                    r_file_offset <= '0;
                    r_status      <= srfo_pkg::ST_INVALID;
                end else begin
                    r_file_offset <= w_last.offset;
                    r_status      <= srfo_pkg::ST_MAPPED;
                end
            end else begin
                r_hit_index <= '0;
                if (w_last.below_first) begin
                    r_file_offset <= w_last.addr;
                    r_status      <= srfo_pkg::ST_HEADER;
                end else begin
                    r_file_offset <= '0;
                    r_status      <= srfo_pkg::ST_INVALID;
                end
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_file_offset = r_file_offset;
    assign o_status      = r_status;
    assign o_hit_index   = r_hit_index;

`ifndef ASSERT_OFF
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == srfo_pkg::ST_INVALID) |-> r_file_offset == '0)
        else $error("invalid result carries a nonzero offset");

    a_header_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == srfo_pkg::ST_HEADER) |-> r_hit_index == '0)
        else $error("header result carries a slot index");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// File: rtl/srfo_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One section table cell: holds one descriptor, writes it on a matching load
// item and matches passing translate items. Depends on srfo_pkg.

module srfo_cell #(
    parameter int P_INDEX = 0
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_advance,
    input  wire logic [srfo_pkg::COUNT_W-1:0]   i_section_count,
    input  wire srfo_pkg::t_token               i_tok,
    output srfo_pkg::t_token                    o_tok
);

    logic [srfo_pkg::ADDR_W-1:0] r_start;
    logic [srfo_pkg::ADDR_W-1:0] r_vsize;
    logic [srfo_pkg::ADDR_W-1:0] r_rsize;
    logic [srfo_pkg::ADDR_W-1:0] r_ptr;
    logic                        r_valid;
    srfo_pkg::t_token            r_tok;
    srfo_pkg::t_token            n_tok;

    logic                        w_write;
    logic                        w_active;
    logic [srfo_pkg::ADDR_W-1:0] w_span;
    logic [srfo_pkg::ADDR_W-1:0] w_end;
    logic                        w_match;

    assign w_write  = i_tok.valid && i_tok.is_load && (int'(i_tok.slot) == P_INDEX);
    assign w_active = int'(i_section_count) > P_INDEX;
    assign w_span   = (r_vsize > r_rsize) ? r_vsize : r_rsize;
    assign w_end    = r_start + w_span;
    assign w_match  = (i_tok.addr >= r_start) && (i_tok.addr < w_end);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.is_load) begin
            if (P_INDEX == 0) begin
                n_tok.below_first = (i_section_count == '0) || (i_tok.addr < r_start);
            end
            if (!i_tok.hit && w_active && w_match) begin
                n_tok.hit     = 1'b1;
                n_tok.hit_idx = srfo_pkg::SLOT_W'(P_INDEX);
                n_tok.offset  = i_tok.addr - r_start + r_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && w_write) begin
            r_start <= i_tok.start;
            r_vsize <= i_tok.vsize;
            r_rsize <= i_tok.rsize;
            r_ptr   <= i_tok.ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= n_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_tok <= n_tok;
        end
    end

    always_comb begin
        o_tok       = r_tok;
        o_tok.valid = r_valid;
    end

endmodule

`default_nettype wire

// File: sim/srfo_checker.sv
`timescale 1ns / 1ps
// Checker for section_rva_to_file_offset_unit: predicts each translation, compares results.
// Watches the item, result and register-write channels; depends on srfo_pkg.

module srfo_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_action,
    input  logic [3:0]  i_entry_index,
    input  logic [31:0] i_entry_virt_start,
    input  logic [31:0] i_entry_virt_size,
    input  logic [31:0] i_entry_raw_size,
    input  logic [31:0] i_entry_raw_pointer,
    input  logic [31:0] i_query_address,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_file_offset,
    input  logic [1:0]  i_status,
    input  logic [3:0]  i_hit_index,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    typedef struct {
        logic [31:0]       offset;
        srfo_pkg::t_status status;
        logic [3:0]        hit;
    } t_translation;

    t_translation pending_translations[$];

    logic [31:0] sec_start [srfo_pkg::MAX_SECTIONS];
    logic [31:0] sec_vsize [srfo_pkg::MAX_SECTIONS];
    logic [31:0] sec_rsize [srfo_pkg::MAX_SECTIONS];
    logic [31:0] sec_rptr  [srfo_pkg::MAX_SECTIONS];
    logic [4:0]  section_count = '0;
    logic [31:0] file_size = '0;
    int          fail_count = 0;
    int          checked = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic t_translation translate_rva(input logic [31:0] rva);
        t_translation res;
        int           used;
        logic [31:0]  span;
        logic [31:0]  stop;
        logic [31:0]  off;
        used       = (section_count > srfo_pkg::MAX_SECTIONS) ? srfo_pkg::MAX_SECTIONS
                                                              : int'(section_count);
        res.offset = rva;
        res.status = srfo_pkg::ST_HEADER;
        res.hit    = '0;
        for (int i = 0; i < used; i++) begin
            span = (sec_vsize[i] > sec_rsize[i]) ? sec_vsize[i] : sec_rsize[i];
            stop = sec_start[i] + span;
            if (rva >= sec_start[i] && rva < stop) begin
                off     = rva - sec_start[i] + sec_rptr[i];
                res.hit = 4'(i);
                if (off > file_size) begin
                    res.offset = '0;
                    res.status = srfo_pkg::ST_INVALID;
                end else begin
                    res.offset = off;
                    res.status = srfo_pkg::ST_MAPPED;
                end
                return res;
            end
        end
        if (used != 0 && rva >= sec_start[0]) begin
            res.offset = '0;
            res.status = srfo_pkg::ST_INVALID;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_translation want;
        if (!i_rst_n) begin
            pending_translations.delete();
            section_count = '0;
            file_size     = '0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_translations.size() == 0) begin
                    $error("unexpected result: file_offset %h status %0d hit_index %0d",
                           i_file_offset, i_status, i_hit_index);
                    fail_count++;
                end else begin
                    want = pending_translations.pop_front();
                    checked++;
                    if (i_file_offset !== want.offset) begin
                        $error("file_offset: expected %h, actual %h", want.offset, i_file_offset);
                        fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fail_count++;
                    end
                    if (i_hit_index !== want.hit) begin
                        $error("hit_index: expected %0d, actual %0d", want.hit, i_hit_index);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == srfo_pkg::CFG_SECTION_COUNT) begin
                    section_count = i_cfg_data[4:0];
                end else begin
                    file_size = i_cfg_data;
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_action == srfo_pkg::ACT_TRANSLATE) begin
                    pending_translations = {pending_translations,
                                            translate_rva(i_query_address)};
                end else begin
                    sec_start[i_entry_index] = i_entry_virt_start;
                    sec_vsize[i_entry_index] = i_entry_virt_size;
                    sec_rsize[i_entry_index] = i_entry_raw_size;
                    sec_rptr[i_entry_index]  = i_entry_raw_pointer;
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_translations.size();
        o_checked    <= checked;
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench top for section_rva_to_file_offset_unit: clock, reset, stimulus and verdict.
// Depends on srfo_pkg, srfo_checker and the block itself.

module testbench;

    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 5000;
    localparam int SEGMENT_ITEMS = 38;

    typedef struct {
        srfo_pkg::t_action act;
        logic [3:0]        slot;
        logic [31:0]       vstart;
        logic [31:0]       vsize;
        logic [31:0]       rsize;
        logic [31:0]       rptr;
        logic [31:0]       addr;
    } t_sec_item;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    srfo_pkg::t_action  action = srfo_pkg::ACT_LOAD;
    logic [3:0]         entry_index = '0;
    logic [31:0]        entry_virt_start = '0;
    logic [31:0]        entry_virt_size = '0;
    logic [31:0]        entry_raw_size = '0;
    logic [31:0]        entry_raw_pointer = '0;
    logic [31:0]        query_address = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [31:0]        file_offset;
    logic [1:0]         status;
    logic [3:0]         hit_index;
    logic               cfg_we = 1'b0;
    srfo_pkg::t_cfg_reg cfg_index = srfo_pkg::CFG_SECTION_COUNT;
    logic [31:0]        cfg_data = '0;

    int          fail_count;
    int          pending;
    int          checked;
    int          send_idle = 32;
    int          recv_idle = 78;
    int          stall_cycles = 0;
    int          items_sent = 0;
    int          settings = 0;
    logic [31:0] tbl_start [srfo_pkg::MAX_SECTIONS];
    logic [31:0] tbl_span  [srfo_pkg::MAX_SECTIONS];

    always #6 clk = ~clk;

    section_rva_to_file_offset_unit DUT (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_action            (action),
        .i_entry_index       (entry_index),
        .i_entry_virt_start  (entry_virt_start),
        .i_entry_virt_size   (entry_virt_size),
        .i_entry_raw_size    (entry_raw_size),
        .i_entry_raw_pointer (entry_raw_pointer),
        .i_query_address     (query_address),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_file_offset       (file_offset),
        .o_status            (status),
        .o_hit_index         (hit_index),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    srfo_checker u_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_ready          (in_ready),
        .i_action            (action),
        .i_entry_index       (entry_index),
        .i_entry_virt_start  (entry_virt_start),
        .i_entry_virt_size   (entry_virt_size),
        .i_entry_raw_size    (entry_raw_size),
        .i_entry_raw_pointer (entry_raw_pointer),
        .i_query_address     (query_address),
        .i_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .i_file_offset       (file_offset),
        .i_status            (status),
        .i_hit_index         (hit_index),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_checked           (checked)
    );

    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_sec_item load_item(input logic [3:0] slot,
                                            input logic [31:0] vstart, vsize, rsize, rptr);
        t_sec_item it;
        it.act    = srfo_pkg::ACT_LOAD;
        it.slot   = slot;
        it.vstart = vstart;
        it.vsize  = vsize;
        it.rsize  = rsize;
        it.rptr   = rptr;
        it.addr   = $urandom();
        return it;
    endfunction

    function automatic t_sec_item query_item(input logic [31:0] addr);
        t_sec_item it;
        it.act    = srfo_pkg::ACT_TRANSLATE;
        it.slot   = 4'($urandom());
        it.vstart = $urandom();
        it.vsize  = $urandom();
        it.rsize  = $urandom();
        it.rptr   = $urandom();
        it.addr   = addr;
        return it;
    endfunction

    task automatic send_item(input t_sec_item it);
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        action            <= it.act;
        entry_index       <= it.slot;
        entry_virt_start  <= it.vstart;
        entry_virt_size   <= it.vsize;
        entry_raw_size    <= it.rsize;
        entry_raw_pointer <= it.rptr;
        query_address     <= it.addr;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // hold off until every translation is back and the chain has flushed its loads
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] count_word, input logic [31:0] fsize);
        cfg_we    <= 1'b1;
        cfg_index <= srfo_pkg::CFG_SECTION_COUNT;
        cfg_data  <= count_word;
        @(posedge clk);
        cfg_index <= srfo_pkg::CFG_FILE_SIZE;
        cfg_data  <= fsize;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial begin
        logic [31:0] cursor;
        logic [31:0] vs;
        logic [31:0] rs;
        logic [31:0] span;
        logic [31:0] addr;
        logic [31:0] count_word;
        logic [31:0] fsize;
        int          slot;
        int          pick;
        t_sec_item   it;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero sections after reset: everything passes through
        send_item(query_item(32'h0000_0000));
        send_item(query_item(32'hFFFF_FFFF));
        send_item(load_item(4'd15, '1, '1, '1, '1));
        send_item(load_item(4'd0, 32'h0000_1000, 32'h0000_0200, 32'h0000_0400, 32'hFFFF_FE00));
        send_item(load_item(4'd1, 32'h0000_2000, 32'h0000_1800, 32'h0000_0600, 32'h0000_0800));
        send_item(load_item(4'd2, 32'h0000_2800, 32'h0000_2000, 32'h0000_0000, 32'h0001_0000));
        send_item(load_item(4'd3, 32'hFFFF_F000, 32'h0000_2000, 32'hFFFF_FFFF, 32'h0000_0000));
        drain();
        set_config(32'd4, 32'hFFFF_FFFF);
        send_item(query_item(32'h0000_0000));
        send_item(query_item(32'h0000_1000));
        send_item(query_item(32'h0000_13FF));
        send_item(query_item(32'h0000_1400));
        send_item(query_item(32'h0000_3000));
        send_item(query_item(32'h0000_3800));
        send_item(query_item(32'hFFFF_FFFF));
        drain();
        set_config(32'd4, 32'h0000_0000);
        send_item(query_item(32'h0000_1000));
        send_item(query_item(32'h0000_1300));
        drain();
        set_config(32'd4, 32'h0000_0100);
        send_item(query_item(32'h0000_1300));
        send_item(query_item(32'h0000_1301));
        send_item(query_item(32'h0000_0000));
        drain();
        set_config(32'd0, $urandom());
        send_item(query_item(32'h0000_1000));

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle = 32;
                    recv_idle = 78;
                end
                1: begin
                    send_idle = 78;
                    recv_idle = 32;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            drain();
            // fresh section layout; sometimes near the top so ends wrap
            cursor = ($urandom_range(0, 3) == 0) ? 32'hFFFF_8000 + $urandom_range(0, 'h4000)
                                                 : $urandom_range(0, 'h8000);
            for (int i = 0; i < srfo_pkg::MAX_SECTIONS; i++) begin
                vs = $urandom_range(0, 'h3000);
                rs = $urandom_range(0, 'h3000);
                if ($urandom_range(0, 7) == 0) begin
                    vs = '0;
                    rs = '0;
                end
                span         = (vs > rs) ? vs : rs;
                tbl_start[i] = cursor;
                tbl_span[i]  = span;
                send_item(load_item(4'(i), cursor, vs, rs, $urandom_range(0, 'h8_0000)));
                cursor = cursor + span + $urandom_range(0, 'h400);
                if ($urandom_range(0, 4) == 0) cursor = cursor - span / 2;
            end

            for (int s = 0; s < 4; s++) begin
                drain();
                case (s)
                    0: begin
                        count_word = 32'd16;
                        fsize      = 32'hFFFF_FFFF;
                    end
                    1: begin
                        count_word = {27'($urandom() >> 5), 5'($urandom_range(17, 31))};
                        fsize      = $urandom_range(0, 'h8_0000);
                    end
                    2: begin
                        count_word = $urandom_range(1, 15);
                        fsize      = ($urandom_range(0, 1) == 0) ? 32'h0
                                                                 : $urandom_range(0, 'h4_0000);
                    end
                    default: begin
                        count_word = (p == 1) ? 32'd0 : ((p == 2) ? 32'd31 : 32'd1);
                        fsize      = $urandom();
                    end
                endcase
                set_config(count_word, fsize);
                repeat (SEGMENT_ITEMS) begin
                    slot = $urandom_range(0, srfo_pkg::MAX_SECTIONS - 1);
                    pick = $urandom_range(0, 99);
                    if (pick < 8) begin
                        it = load_item(4'(slot), $urandom(), $urandom(), $urandom(), $urandom());
                        tbl_start[slot] = it.vstart;
                        tbl_span[slot]  = (it.vsize > it.rsize) ? it.vsize : it.rsize;
                        send_item(it);
                    end else if (pick < 16) begin
                        vs = $urandom_range(0, 'h3000);
                        rs = $urandom_range(0, 'h3000);
                        tbl_span[slot] = (vs > rs) ? vs : rs;
                        send_item(load_item(4'(slot), tbl_start[slot], vs, rs,
                                            $urandom_range(0, 'h8_0000)));
                    end else begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4, 5: addr = tbl_start[slot] + ((tbl_span[slot] == 0) ?
                                32'h0 : $urandom_range(0, tbl_span[slot] - 1));
                            6: addr = tbl_start[slot];
                            7: addr = tbl_start[slot] + tbl_span[slot] - $urandom_range(0, 1);
                            8: addr = (tbl_start[0] == 0) ? 32'h0
                                                          : $urandom_range(0, tbl_start[0] - 1);
                            default: addr = $urandom();
                        endcase
                        send_item(query_item(addr));
                    end
                end
            end
        end

        drain();
        $display("Sent %0d items, checked %0d translations over %0d register settings,",
                 items_sent, checked, settings);
        $display("with stall mixes 32/78, 78/32 and none on the sender/receiver sides.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/srfo_pkg.sv
rtl/srfo_cell.sv
rtl/section_rva_to_file_offset_unit.sv
sim/srfo_checker.sv
sim/testbench.sv
